FILE: rtl/core/sst_pkg.sv
// shared types, constants and character classes for the source tokenizer
// no dependencies
package sst_pkg;

   localparam int LINE_BITS   = 16;
   localparam int COLUMN_BITS = 16;
   localparam int MAX_RESULTS = 4;
   localparam int SLOT_BITS   = 2;

   localparam logic [5:0] KIND_END    = 6'd0;
   localparam logic [5:0] KIND_IDENT  = 6'd1;
   localparam logic [5:0] KIND_INT    = 6'd2;
   localparam logic [5:0] KIND_REAL   = 6'd3;
   localparam logic [5:0] KIND_STRING = 6'd4;
   localparam logic [5:0] KIND_ERROR  = 6'd38;
   localparam logic [6:0] PAIR_LINE   = 7'd100;
   localparam logic [6:0] PAIR_BLOCK  = 7'd101;
   localparam logic [6:0] PAIR_NONE   = 7'd0;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_HELD, MODE_IDENT, MODE_INT, MODE_REAL,
      MODE_STRING, MODE_LINE_CMT, MODE_BLOCK_CMT, MODE_ERROR
   } mode_type;

   typedef struct packed {
      logic [5:0]             kind;
      logic [7:0]             value_char;
      logic                   has_char;
      logic                   done;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] column;
   } result_type;

   typedef struct packed {
      mode_type               mode;
      logic [7:0]             held_char;
      logic                   held_valid;
      logic                   escape_pending;
      logic [LINE_BITS-1:0]   line_count;
      logic [COLUMN_BITS-1:0] column_count;
      logic                   error_latched;
      logic                   byte_taken;
      logic                   last_was_lf;
   } state_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_ident(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) ||
             c == "_" || c == "$";
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      unique case (c)
         "{": return 6'd5;   "}": return 6'd6;   "[": return 6'd7;  "]": return 6'd8;
         "(": return 6'd31;  ")": return 6'd32;  ";": return 6'd33; ",": return 6'd34;
         ":": return 6'd35;  ".": return 6'd36;
         default: return 6'd0;
      endcase
   endfunction

   function automatic logic is_starter(input logic [7:0] c);
      return c == "/" || c == "#" || c == "&" || c == "|" || c == "=" || c == "!" ||
             c == ">" || c == "<" || c == "+" || c == "-" || c == "*" || c == "%";
   endfunction

   function automatic logic [5:0] lone_kind(input logic [7:0] h);
      unique case (h)
         "=": return 6'd17; "!": return 6'd18; ">": return 6'd15; "<": return 6'd16;
         "+": return 6'd26; "-": return 6'd27; "*": return 6'd28; "/": return 6'd29;
         "%": return 6'd30; "#": return 6'd37;
         default: return 6'd0;
      endcase
   endfunction

   function automatic logic [6:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
      logic [6:0] k;
      k = PAIR_NONE;
      if (h == "/" && c == "/") k = PAIR_LINE;
      else if (h == "#" && c == "!") k = PAIR_LINE;
      else if (h == "/" && c == "*") k = PAIR_BLOCK;
      else if (h == "&" && c == "&") k = 7'd9;
      else if (h == "|" && c == "|") k = 7'd10;
      else if (h == "+" && c == "+") k = 7'd19;
      else if (h == "-" && c == "-") k = 7'd20;
      else if (c == "=") begin
         unique case (h)
            "=": k = 7'd11; "!": k = 7'd12; ">": k = 7'd13; "<": k = 7'd14;
            "+": k = 7'd21; "-": k = 7'd22; "*": k = 7'd23; "/": k = 7'd24;
            "%": k = 7'd25;
            default: k = PAIR_NONE;
         endcase
      end
      return k;
   endfunction

endpackage

FILE: rtl/core/sst_scan.sv
// combinational scanner step: current state and one byte to next state and results
// depends on sst_pkg
module sst_scan (
   input  sst_pkg::state_type  cur,
   input  logic [7:0]          char_in,
   input  logic                end_of_text,
   output sst_pkg::state_type  nxt,
   output sst_pkg::result_type res [sst_pkg::MAX_RESULTS],
   output logic [2:0]          res_count
);

   localparam logic [sst_pkg::LINE_BITS-1:0]   LINE_TOP   = '1;
   localparam logic [sst_pkg::COLUMN_BITS-1:0] COLUMN_TOP = '1;
   localparam logic [sst_pkg::LINE_BITS-1:0]   LINE_ONE   = sst_pkg::LINE_BITS'(1);
   localparam logic [sst_pkg::COLUMN_BITS-1:0] COLUMN_ONE = sst_pkg::COLUMN_BITS'(1);

   logic [sst_pkg::LINE_BITS-1:0]   ln, nl, pl;
   logic [sst_pkg::COLUMN_BITS-1:0] cl, nc, pc;
   sst_pkg::state_type s;
   sst_pkg::result_type r [sst_pkg::MAX_RESULTS];
   logic [2:0] cnt;
   logic [7:0] c, h, t;
   logic [6:0] p;
   logic [5:0] k;
   logic       go_idle, esc_ok;

   always_comb begin
      c = char_in;
      ln = cur.line_count;
      cl = cur.column_count;
      if (cur.byte_taken) begin
         if (cur.last_was_lf) begin
            ln = (ln == LINE_TOP) ? ln : ln + LINE_ONE;
            cl = '0;
         end
         cl = (cl == COLUMN_TOP) ? cl : cl + COLUMN_ONE;
      end
      s = cur;
      s.line_count = ln;
      s.column_count = cl;
      s.byte_taken = 1'b1;
      s.last_was_lf = (c == 8'h0a);
      for (int i = 0; i < sst_pkg::MAX_RESULTS; i++) r[i] = '0;
      cnt = '0;
      go_idle = 1'b0;
      h = cur.held_char;
      p = sst_pkg::pair_kind(h, c);
      k = '0;
      t = c;
      esc_ok = 1'b1;
      if (c == 8'h0a) begin
         nl = (ln == LINE_TOP) ? ln : ln + LINE_ONE;
         nc = end_of_text ? '0 : COLUMN_ONE;
      end else begin
         nl = ln;
         nc = end_of_text ? cl : ((cl == COLUMN_TOP) ? cl : cl + COLUMN_ONE);
      end
      pl = (c == 8'h00) ? ln : nl;
      pc = (c == 8'h00) ? cl : nc;

      if (c != 8'h00) begin
         unique case (cur.mode)
            sst_pkg::MODE_IDLE: go_idle = 1'b1;
            sst_pkg::MODE_HELD: begin
               s.held_char = '0;
               s.held_valid = 1'b0;
               if (p == sst_pkg::PAIR_LINE) s.mode = sst_pkg::MODE_LINE_CMT;
               else if (p == sst_pkg::PAIR_BLOCK) s.mode = sst_pkg::MODE_BLOCK_CMT;
               else if (p != sst_pkg::PAIR_NONE) begin
                  r[0] = '{p[5:0], 8'h00, 1'b0, 1'b1, nl, nc};
                  cnt = 3'd1;
                  s.mode = sst_pkg::MODE_IDLE;
               end else if (sst_pkg::lone_kind(h) == 6'd0) begin
                  r[0] = '{sst_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, ln, cl};
                  cnt = 3'd1;
                  s.mode = sst_pkg::MODE_ERROR;
                  s.error_latched = 1'b1;
               end else begin
                  r[0] = '{sst_pkg::lone_kind(h), 8'h00, 1'b0, 1'b1, ln, cl};
                  cnt = 3'd1;
                  go_idle = 1'b1;
               end
            end
            sst_pkg::MODE_IDENT: begin
               if (sst_pkg::is_ident(c)) begin
                  r[0] = '{sst_pkg::KIND_IDENT, c, 1'b1, 1'b0, ln, cl};
                  cnt = 3'd1;
               end else begin
                  r[0] = '{sst_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1, ln, cl};
                  cnt = 3'd1;
                  go_idle = 1'b1;
               end
            end
            sst_pkg::MODE_INT: begin
               if (sst_pkg::is_digit(c)) begin
                  r[0] = '{sst_pkg::KIND_INT, c, 1'b1, 1'b0, ln, cl};
                  cnt = 3'd1;
               end else if (c == ".") begin
                  r[0] = '{sst_pkg::KIND_REAL, c, 1'b1, 1'b0, ln, cl};
                  cnt = 3'd1;
                  s.mode = sst_pkg::MODE_REAL;
               end else begin
                  r[0] = '{sst_pkg::KIND_INT, 8'h00, 1'b0, 1'b1, ln, cl};
                  cnt = 3'd1;
                  go_idle = 1'b1;
               end
            end
            sst_pkg::MODE_REAL: begin
               if (sst_pkg::is_digit(c)) begin
                  r[0] = '{sst_pkg::KIND_REAL, c, 1'b1, 1'b0, ln, cl};
                  cnt = 3'd1;
               end else begin
                  r[0] = '{sst_pkg::KIND_REAL, 8'h00, 1'b0, 1'b1, ln, cl};
                  cnt = 3'd1;
                  go_idle = 1'b1;
               end
            end
            sst_pkg::MODE_STRING: begin
               if (cur.escape_pending) begin
                  s.escape_pending = 1'b0;
                  unique case (c)
                     8'h22: t = 8'h22;
                     8'h5c: t = 8'h5c;
                     "n": t = 8'd10;
                     "r": t = 8'd13;
                     "t": t = 8'd9;
                     "a": t = 8'd7;
                     "b": t = 8'd8;
                     "v": t = 8'd11;
                     default: begin
                        t = c;
                        esc_ok = 1'b0;
                     end
                  endcase
                  if (esc_ok) begin
                     r[0] = '{sst_pkg::KIND_STRING, t, 1'b1, 1'b0, ln, cl};
                     cnt = 3'd1;
                  end else begin
                     r[0] = '{sst_pkg::KIND_STRING, 8'h5c, 1'b1, 1'b0, ln, cl};
                     r[1] = '{sst_pkg::KIND_STRING, t, 1'b1, 1'b0, ln, cl};
                     cnt = 3'd2;
                  end
               end else if (c == 8'h5c) begin
                  s.escape_pending = 1'b1;
               end else if (c == 8'h22) begin
                  r[0] = '{sst_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, nl, nc};
                  cnt = 3'd1;
                  s.mode = sst_pkg::MODE_IDLE;
               end else begin
                  r[0] = '{sst_pkg::KIND_STRING, c, 1'b1, 1'b0, ln, cl};
                  cnt = 3'd1;
               end
            end
            sst_pkg::MODE_LINE_CMT: begin
               if (c == 8'h0a) s.mode = sst_pkg::MODE_IDLE;
            end
            sst_pkg::MODE_BLOCK_CMT: begin
               if (cur.held_valid && c == "/") begin
                  s.held_valid = 1'b0;
                  s.held_char = '0;
                  s.mode = sst_pkg::MODE_IDLE;
               end else begin
                  s.held_valid = (c == "*");
                  s.held_char = (c == "*") ? c : 8'h00;
               end
            end
            default: begin
               s.mode = sst_pkg::MODE_ERROR;
               s.error_latched = 1'b1;
            end
         endcase

         // byte starts fresh from between tokens
         if (go_idle) begin
            s.mode = sst_pkg::MODE_IDLE;
            k = sst_pkg::single_kind(c);
            if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
            end else if (k != 6'd0) begin
               r[cnt[1:0]] = '{k, 8'h00, 1'b0, 1'b1, nl, nc};
               cnt = cnt + 3'd1;
            end else if (c == 8'h22) begin
               s.mode = sst_pkg::MODE_STRING;
               s.escape_pending = 1'b0;
            end else if (sst_pkg::is_digit(c)) begin
               s.mode = sst_pkg::MODE_INT;
               r[cnt[1:0]] = '{sst_pkg::KIND_INT, c, 1'b1, 1'b0, ln, cl};
               cnt = cnt + 3'd1;
            end else if (sst_pkg::is_ident(c)) begin
               s.mode = sst_pkg::MODE_IDENT;
               r[cnt[1:0]] = '{sst_pkg::KIND_IDENT, c, 1'b1, 1'b0, ln, cl};
               cnt = cnt + 3'd1;
            end else if (sst_pkg::is_starter(c)) begin
               s.mode = sst_pkg::MODE_HELD;
               s.held_char = c;
               s.held_valid = 1'b1;
            end else begin
               r[cnt[1:0]] = '{sst_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, ln, cl};
               cnt = cnt + 3'd1;
               s.mode = sst_pkg::MODE_ERROR;
               s.error_latched = 1'b1;
            end
         end
      end

      // end of text: flush open token, end marker, back to reset state
      if (c == 8'h00 || end_of_text) begin
         unique case (s.mode)
            sst_pkg::MODE_IDENT: begin
               r[cnt[1:0]] = '{sst_pkg::KIND_IDENT, 8'h00, 1'b0, 1'b1, pl, pc};
               cnt = cnt + 3'd1;
            end
            sst_pkg::MODE_INT: begin
               r[cnt[1:0]] = '{sst_pkg::KIND_INT, 8'h00, 1'b0, 1'b1, pl, pc};
               cnt = cnt + 3'd1;
            end
            sst_pkg::MODE_REAL: begin
               r[cnt[1:0]] = '{sst_pkg::KIND_REAL, 8'h00, 1'b0, 1'b1, pl, pc};
               cnt = cnt + 3'd1;
            end
            sst_pkg::MODE_STRING: begin
               if (s.escape_pending) begin
                  r[cnt[1:0]] = '{sst_pkg::KIND_STRING, 8'h5c, 1'b1, 1'b0, ln, cl};
                  cnt = cnt + 3'd1;
               end
               r[cnt[1:0]] = '{sst_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, pl, pc};
               cnt = cnt + 3'd1;
            end
            sst_pkg::MODE_HELD: begin
               if (sst_pkg::lone_kind(s.held_char) == 6'd0)
                  r[cnt[1:0]] = '{sst_pkg::KIND_ERROR, 8'h00, 1'b0, 1'b1, ln, cl};
               else
                  r[cnt[1:0]] = '{sst_pkg::lone_kind(s.held_char), 8'h00, 1'b0, 1'b1,
                                  pl, pc};
               cnt = cnt + 3'd1;
            end
            default: begin
            end
         endcase
         r[cnt[1:0]] = '{sst_pkg::KIND_END, 8'h00, 1'b0, 1'b1, pl, pc};
         cnt = cnt + 3'd1;
         s = '{sst_pkg::MODE_IDLE, 8'h00, 1'b0, 1'b0, LINE_ONE, COLUMN_ONE,
               1'b0, 1'b0, 1'b0};
      end
      nxt = s;
      res = r;
      res_count = cnt;
   end

endmodule

FILE: rtl/core/sst_out.sv
// result buffer: holds up to four results of one byte and hands them out one a cycle
// while rsp_stall is low; depends on sst_pkg
module sst_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sst_pkg::result_type load_res [sst_pkg::MAX_RESULTS],
   input  logic [2:0]          load_count,
   output logic                busy,
   output logic                last_slot,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [5:0]          rsp_token_kind,
   output logic [7:0]          rsp_value_char,
   output logic                rsp_has_char,
   output logic                rsp_token_done,
   output logic [15:0]         rsp_line_number,
   output logic [15:0]         rsp_column_number,
   output logic                rsp_run_last
);

   sst_pkg::result_type buf_ff [sst_pkg::MAX_RESULTS];
   logic [2:0] left_ff, left_in;
   logic [sst_pkg::SLOT_BITS-1:0] pos_ff, pos_in;
   sst_pkg::result_type cur;

   assign cur = buf_ff[pos_ff];
   assign rsp_valid = left_ff != 3'd0;
   assign last_slot = left_ff == 3'd1;
   assign busy = left_ff > 3'd1 || (left_ff == 3'd1 && rsp_stall);
   assign rsp_token_kind = cur.kind;
   assign rsp_value_char = cur.value_char;
   assign rsp_has_char = cur.has_char;
   assign rsp_token_done = cur.done;
   assign rsp_line_number = cur.line;
   assign rsp_column_number = cur.column;
   assign rsp_run_last = last_slot;

   always_comb begin
      left_in = left_ff;
      pos_in = pos_ff;
      if (rsp_valid && !rsp_stall) begin
         left_in = left_ff - 3'd1;
         pos_in = pos_ff + sst_pkg::SLOT_BITS'(1);
      end
      if (load) begin
         left_in = load_count;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         pos_ff <= '0;
      end else begin
         left_ff <= left_in;
         pos_ff <= pos_in;
      end
      if (load) buf_ff <= load_res;
   end

endmodule

FILE: rtl/core/script_source_tokenizer.sv
// top level of the source tokenizer: state register, scanner step and result buffer
// depends on sst_pkg, sst_scan and sst_out
// takes one source byte per request and gives 0 to 4 results per byte, one result
// per cycle on the rsp channel unless rsp_stall; a byte is scanned in the cycle it is
// accepted and its results land in a four-entry result buffer, so a byte with at most
// one result sustains one byte per cycle unless rsp_stall, and a byte with more results
// holds req_stall while the buffer drains; a byte whose results are all empty (blanks,
// comments) passes without touching the rsp side. run_last marks the last result of
// each byte. byte 0 or end_of_text closes the text and returns to reset state
module script_source_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_token_kind,
   output logic [7:0]  rsp_value_char,
   output logic        rsp_has_char,
   output logic        rsp_token_done,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic        rsp_run_last
);

   sst_pkg::state_type  state_ff, state_in;
   sst_pkg::result_type step_res [sst_pkg::MAX_RESULTS];
   logic [2:0] step_count;
   logic       out_busy, out_last, take, load;

   // scanner step on the incoming byte
   sst_scan u_scan (
      .cur(state_ff),
      .char_in(req_char_in),
      .end_of_text(req_end_of_text),
      .nxt(state_in),
      .res(step_res),
      .res_count(step_count)
   );

   // accept while the buffer is empty or its last result leaves this cycle
   assign req_stall = out_busy;
   assign take = req_valid && !req_stall;
   // only reload the buffer when the byte produced something
   assign load = take && step_count != 3'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{sst_pkg::MODE_IDLE, 8'h00, 1'b0, 1'b0,
                       sst_pkg::LINE_BITS'(1), sst_pkg::COLUMN_BITS'(1),
                       1'b0, 1'b0, 1'b0};
      end else if (take) begin
         state_ff <= state_in;
      end
   end

   sst_out u_out (
      .clock(clock),
      .reset(reset),
      .load(load),
      .load_res(step_res),
      .load_count(step_count),
      .busy(out_busy),
      .last_slot(out_last),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_token_kind(rsp_token_kind),
      .rsp_value_char(rsp_value_char),
      .rsp_has_char(rsp_has_char),
      .rsp_token_done(rsp_token_done),
      .rsp_line_number(rsp_line_number),
      .rsp_column_number(rsp_column_number),
      .rsp_run_last(rsp_run_last)
   );

endmodule

FILE: verif/sst_checker.sv
`timescale 1ns / 1ps
// watches the request and result channels of the source tokenizer, predicts
// the token stream of every accepted byte and compares; depends on sst_pkg
module sst_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_token_kind,
   input  logic [7:0]  rsp_value_char,
   input  logic        rsp_has_char,
   input  logic        rsp_token_done,
   input  logic [15:0] rsp_line_number,
   input  logic [15:0] rsp_column_number,
   input  logic        rsp_run_last,
   output int          mismatch_count,
   output int          tokens_waiting
);

   typedef enum logic [5:0] {
      TK_LBRACE = 6'd5, TK_RBRACE, TK_LBRACK, TK_RBRACK, TK_AND_AND, TK_OR_OR,
      TK_EQ_EQ, TK_NOT_EQ, TK_GE, TK_LE, TK_GT, TK_LT, TK_ASSIGN, TK_NOT, TK_INC,
      TK_DEC, TK_ADD_ASSIGN, TK_SUB_ASSIGN, TK_MUL_ASSIGN, TK_DIV_ASSIGN,
      TK_MOD_ASSIGN, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_PERCENT, TK_LPAREN,
      TK_RPAREN, TK_SEMI, TK_COMMA, TK_COLON, TK_DOT, TK_HASH
   } op_kind_type;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;

   typedef struct packed {
      sst_pkg::result_type tok;
      logic                last;
   } token_rec_type;

   token_rec_type token_q[$];
   token_rec_type byte_toks[$];

   sst_pkg::mode_type mode;
   logic [7:0]       held;
   logic             held_v, esc, err_flag, taken, prev_lf;
   logic [15:0]      lcnt, ccnt;

   function automatic logic [15:0] sat16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic digit_ch(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic word_ch(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || digit_ch(c) ||
             c == "_" || c == "$";
   endfunction

   function automatic logic [5:0] punct_of(input logic [7:0] c);
      case (c)
         "{": return TK_LBRACE;  "}": return TK_RBRACE;
         "[": return TK_LBRACK;  "]": return TK_RBRACK;
         "(": return TK_LPAREN;  ")": return TK_RPAREN;
         ";": return TK_SEMI;    ",": return TK_COMMA;
         ":": return TK_COLON;   ".": return TK_DOT;
         default: return sst_pkg::KIND_END;
      endcase
   endfunction

   function automatic logic opener(input logic [7:0] c);
      case (c)
         "/", "#", "&", "|", "=", "!", ">", "<", "+", "-", "*", "%": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [5:0] single_op(input logic [7:0] h);
      case (h)
         "=": return TK_ASSIGN;  "!": return TK_NOT;     ">": return TK_GT;
         "<": return TK_LT;      "+": return TK_PLUS;    "-": return TK_MINUS;
         "*": return TK_STAR;    "/": return TK_SLASH;   "%": return TK_PERCENT;
         "#": return TK_HASH;
         default: return sst_pkg::KIND_END;
      endcase
   endfunction

   function automatic logic [6:0] double_op(input logic [7:0] h, input logic [7:0] c);
      if (h == "/" && c == "/") return sst_pkg::PAIR_LINE;
      if (h == "#" && c == "!") return sst_pkg::PAIR_LINE;
      if (h == "/" && c == "*") return sst_pkg::PAIR_BLOCK;
      if (h == "&" && c == "&") return TK_AND_AND;
      if (h == "|" && c == "|") return TK_OR_OR;
      if (h == "+" && c == "+") return TK_INC;
      if (h == "-" && c == "-") return TK_DEC;
      if (c == "=") begin
         case (h)
            "=": return TK_EQ_EQ;      "!": return TK_NOT_EQ;
            ">": return TK_GE;         "<": return TK_LE;
            "+": return TK_ADD_ASSIGN; "-": return TK_SUB_ASSIGN;
            "*": return TK_MUL_ASSIGN; "/": return TK_DIV_ASSIGN;
            "%": return TK_MOD_ASSIGN;
            default: return sst_pkg::PAIR_NONE;
         endcase
      end
      return sst_pkg::PAIR_NONE;
   endfunction

   function automatic void emit(input logic [5:0] k, input logic [7:0] ch, input logic has,
                                input logic dn, input logic [15:0] ln,
                                input logic [15:0] cl);
      token_rec_type t;
      if (byte_toks.size() >= sst_pkg::MAX_RESULTS) return;
      t.tok.kind = k;
      t.tok.value_char = has ? ch : 8'd0;
      t.tok.has_char = has;
      t.tok.done = dn;
      t.tok.line = ln;
      t.tok.column = cl;
      t.last = 1'b0;
      byte_toks.push_back(t);
   endfunction

   function automatic void emit_char(input logic [5:0] k, input logic [7:0] ch);
      emit(k, ch, 1'b1, 1'b0, lcnt, ccnt);
   endfunction

   function automatic void emit_close(input logic [5:0] k, input logic [15:0] ln,
                                      input logic [15:0] cl);
      emit(k, 8'd0, 1'b0, 1'b1, ln, cl);
   endfunction

   function automatic void raise_error();
      emit_close(sst_pkg::KIND_ERROR, lcnt, ccnt);
      mode = sst_pkg::MODE_ERROR;
      err_flag = 1'b1;
   endfunction

   function automatic void clear_scan();
      mode = sst_pkg::MODE_IDLE;
      held = 8'd0;
      held_v = 1'b0;
      esc = 1'b0;
      lcnt = 16'd1;
      ccnt = 16'd1;
      err_flag = 1'b0;
      taken = 1'b0;
      prev_lf = 1'b0;
   endfunction

   function automatic void start_token(input logic [7:0] c, input logic [15:0] nl,
                                       input logic [15:0] nc);
      mode = sst_pkg::MODE_IDLE;
      if (c == " " || c == CH_TAB || c == CH_CR || c == CH_LF) return;
      if (punct_of(c) != sst_pkg::KIND_END) begin
         emit_close(punct_of(c), nl, nc);
      end else if (c == "\"") begin
         mode = sst_pkg::MODE_STRING;
         esc = 1'b0;
      end else if (digit_ch(c)) begin
         mode = sst_pkg::MODE_INT;
         emit_char(sst_pkg::KIND_INT, c);
      end else if (word_ch(c)) begin
         mode = sst_pkg::MODE_IDENT;
         emit_char(sst_pkg::KIND_IDENT, c);
      end else if (opener(c)) begin
         mode = sst_pkg::MODE_HELD;
         held = c;
         held_v = 1'b1;
      end else begin
         raise_error();
      end
   endfunction

   function automatic void string_byte(input logic [7:0] c, input logic [15:0] nl,
                                       input logic [15:0] nc);
      logic [7:0] t;
      if (esc) begin
         esc = 1'b0;
         case (c)
            "\"": t = "\"";
            "\\": t = "\\";
            "n":  t = 8'd10;
            "r":  t = 8'd13;
            "t":  t = 8'd9;
            "a":  t = 8'd7;
            "b":  t = 8'd8;
            "v":  t = 8'd11;
            default: begin
               emit_char(sst_pkg::KIND_STRING, "\\");
               t = c;
            end
         endcase
         emit_char(sst_pkg::KIND_STRING, t);
      end else if (c == "\\") begin
         esc = 1'b1;
      end else if (c == "\"") begin
         emit_close(sst_pkg::KIND_STRING, nl, nc);
         mode = sst_pkg::MODE_IDLE;
      end else begin
         emit_char(sst_pkg::KIND_STRING, c);
      end
   endfunction

   function automatic void close_text(input logic [15:0] pl, input logic [15:0] pc);
      case (mode)
         sst_pkg::MODE_IDENT: emit_close(sst_pkg::KIND_IDENT, pl, pc);
         sst_pkg::MODE_INT:   emit_close(sst_pkg::KIND_INT, pl, pc);
         sst_pkg::MODE_REAL:  emit_close(sst_pkg::KIND_REAL, pl, pc);
         sst_pkg::MODE_STRING: begin
            if (esc) emit_char(sst_pkg::KIND_STRING, "\\");
            emit_close(sst_pkg::KIND_STRING, pl, pc);
         end
         sst_pkg::MODE_HELD: begin
            if (single_op(held) == sst_pkg::KIND_END)
               emit_close(sst_pkg::KIND_ERROR, lcnt, ccnt);
            else emit_close(single_op(held), pl, pc);
         end
         default: ;
      endcase
      emit_close(sst_pkg::KIND_END, pl, pc);
      clear_scan();
   endfunction

   // one accepted source byte: advances the counters and appends its tokens
   function automatic void scan_byte(input logic [7:0] c, input logic eot);
      logic [15:0] nl, nc;
      logic [6:0]  p;
      logic [7:0]  h;
      byte_toks.delete();
      if (taken) begin
         if (prev_lf) begin
            lcnt = sat16(lcnt);
            ccnt = 16'd0;
         end
         ccnt = sat16(ccnt);
      end
      taken = 1'b1;
      prev_lf = (c == CH_LF);
      if (c == CH_NUL) begin
         close_text(lcnt, ccnt);
      end else begin
         if (c == CH_LF) begin
            nl = sat16(lcnt);
            nc = eot ? 16'd0 : 16'd1;
         end else begin
            nl = lcnt;
            nc = eot ? ccnt : sat16(ccnt);
         end
         case (mode)
            sst_pkg::MODE_IDLE: start_token(c, nl, nc);
            sst_pkg::MODE_HELD: begin
               h = held;
               p = double_op(h, c);
               held = 8'd0;
               held_v = 1'b0;
               if (p == sst_pkg::PAIR_LINE) mode = sst_pkg::MODE_LINE_CMT;
               else if (p == sst_pkg::PAIR_BLOCK) mode = sst_pkg::MODE_BLOCK_CMT;
               else if (p != sst_pkg::PAIR_NONE) begin
                  emit_close(p[5:0], nl, nc);
                  mode = sst_pkg::MODE_IDLE;
               end else if (single_op(h) == sst_pkg::KIND_END) begin
                  raise_error();
               end else begin
                  emit_close(single_op(h), lcnt, ccnt);
                  start_token(c, nl, nc);
               end
            end
            sst_pkg::MODE_IDENT: begin
               if (word_ch(c)) emit_char(sst_pkg::KIND_IDENT, c);
               else begin
                  emit_close(sst_pkg::KIND_IDENT, lcnt, ccnt);
                  start_token(c, nl, nc);
               end
            end
            sst_pkg::MODE_INT: begin
               if (digit_ch(c)) emit_char(sst_pkg::KIND_INT, c);
               else if (c == ".") begin
                  emit_char(sst_pkg::KIND_REAL, c);
                  mode = sst_pkg::MODE_REAL;
               end else begin
                  emit_close(sst_pkg::KIND_INT, lcnt, ccnt);
                  start_token(c, nl, nc);
               end
            end
            sst_pkg::MODE_REAL: begin
               if (digit_ch(c)) emit_char(sst_pkg::KIND_REAL, c);
               else begin
                  emit_close(sst_pkg::KIND_REAL, lcnt, ccnt);
                  start_token(c, nl, nc);
               end
            end
            sst_pkg::MODE_STRING: string_byte(c, nl, nc);
            sst_pkg::MODE_LINE_CMT: if (c == CH_LF) mode = sst_pkg::MODE_IDLE;
            sst_pkg::MODE_BLOCK_CMT: begin
               if (held_v && c == "/") begin
                  held_v = 1'b0;
                  held = 8'd0;
                  mode = sst_pkg::MODE_IDLE;
               end else begin
                  held_v = (c == "*");
                  held = held_v ? c : 8'd0;
               end
            end
            default: begin
               mode = sst_pkg::MODE_ERROR;
               err_flag = 1'b1;
            end
         endcase
         if (eot) close_text(nl, nc);
      end
      if (byte_toks.size() > 0) byte_toks[byte_toks.size()-1].last = 1'b1;
      foreach (byte_toks[i]) token_q.push_back(byte_toks[i]);
   endfunction

   function automatic void report(input string what, input token_rec_type e,
                                  input token_rec_type a);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t token mismatch (%s): expected kind=%0d ch=%h has=%b done=%b",
                  $realtime, what, e.tok.kind, e.tok.value_char, e.tok.has_char,
                  e.tok.done);
         $display("   expected line=%0d col=%0d last=%b", e.tok.line, e.tok.column,
                  e.last);
         $display("   got kind=%0d ch=%h has=%b done=%b line=%0d col=%0d last=%b",
                  a.tok.kind, a.tok.value_char, a.tok.has_char, a.tok.done,
                  a.tok.line, a.tok.column, a.last);
      end
   endfunction

   initial begin
      mismatch_count = 0;
      tokens_waiting = 0;
      clear_scan();
   end

   always @(posedge clock) begin
      token_rec_type seen, want;
      if (reset) begin
         clear_scan();
         token_q.delete();
      end else begin
         if (req_valid && !req_stall) scan_byte(req_char_in, req_end_of_text);
         if (rsp_valid && !rsp_stall) begin
            seen.tok.kind = rsp_token_kind;
            seen.tok.value_char = rsp_value_char;
            seen.tok.has_char = rsp_has_char;
            seen.tok.done = rsp_token_done;
            seen.tok.line = rsp_line_number;
            seen.tok.column = rsp_column_number;
            seen.last = rsp_run_last;
            if (token_q.size() == 0) begin
               want = '0;
               report("unexpected", want, seen);
            end else begin
               want = token_q.pop_front();
               if (want != seen) report("fields", want, seen);
            end
         end
      end
      tokens_waiting <= token_q.size();
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// stimulus and verdict for the source tokenizer: drives source text, stalls the
// result side; depends on script_source_tokenizer, sst_checker and sst_pkg
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'd0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [7:0]  rsp_value_char;
   logic        rsp_has_char;
   logic        rsp_token_done;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic        rsp_run_last;
   int          mismatch_count;
   int          tokens_waiting;

   // receiver hold-off requests: the stimulus bumps hold_ask, the receiver answers
   int          hold_ask = 0;
   int          hold_seen = 0;
   // sender burst bookkeeping
   int          burst_left = 0;
   int          random_sent = 0;
   logic [7:0]  text_q[$];

   always #2 clock = ~clock;

   script_source_tokenizer dut (.*);

   sst_checker u_checker (.*);

   // ---- request side -----------------------------------------------------
   // one byte per request; valid stays high across a burst and drops in gaps
   task automatic send_byte(input logic [7:0] c, input logic eot);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_char_in <= c;
      req_end_of_text <= eot;
      req_valid <= 1'b1;
      // stall is sampled at the edge itself, before the block updates
      @(posedge clock iff !req_stall);
   endtask

   // sends the queued text; the last byte carries end_of_text when asked
   task automatic send_text(input bit flag_end);
      foreach (text_q[i]) send_byte(text_q[i], flag_end && i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // stops offering and waits until every expected token has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tokens_waiting != 0);
   endtask

   // ---- random text generation ---------------------------------------------
   function automatic logic [7:0] pick_char(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      return 8'($urandom_range(lo, hi));
   endfunction

   // appends one lexical piece: well-formed tokens mostly, with some noise
   task automatic add_fragment();
      string ops[] = '{"&&", "||", "==", "!=", ">=", "<=", ">", "<", "=", "!", "++", "--",
                       "+=", "-=", "*=", "/=", "%=", "+", "-", "*", "/", "%", "#", "&", "|"};
      string letters = "abcxyzABQZ_$";
      string wordset = "azAZ09_$mK";
      string escs = "\"\\nrtabvq0x";
      int n;
      case ($urandom_range(0, 13))
         0, 1: begin
            text_q.push_back(pick_char(letters));
            n = $urandom_range(0, 5);
            repeat (n) text_q.push_back(pick_char(wordset));
         end
         2: repeat ($urandom_range(1, 4)) text_q.push_back(rand_byte("0", "9"));
         3: begin
            repeat ($urandom_range(1, 3)) text_q.push_back(rand_byte("0", "9"));
            text_q.push_back(".");
            repeat ($urandom_range(0, 3)) text_q.push_back(rand_byte("0", "9"));
         end
         4: begin
            text_q.push_back("\"");
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(0, 2) == 0) begin
                  text_q.push_back("\\");
                  text_q.push_back(pick_char(escs));
               end else begin
                  text_q.push_back(rand_byte(32, 126));
               end
            end
            if ($urandom_range(0, 9) != 0) text_q.push_back("\"");
         end
         5, 6: push_str(ops[$urandom_range(0, ops.size() - 1)]);
         7: repeat ($urandom_range(1, 3)) text_q.push_back(pick_char(" \t\r\n"));
         8: begin
            push_str($urandom_range(0, 1) ? "//" : "#!");
            repeat ($urandom_range(0, 4)) text_q.push_back(rand_byte(1, 9));
            text_q.push_back(8'h0A);
         end
         9: begin
            push_str("/*");
            repeat ($urandom_range(0, 5)) text_q.push_back(pick_char("*/a \n"));
            push_str("*/");
         end
         10: text_q.push_back(pick_char("{}[]();,:."));
         11: text_q.push_back(rand_byte(0, 255));
         default: text_q.push_back(" ");
      endcase
   endtask

   // ---- receiver side: its own stall pattern, plus long hold-offs ------------
   initial begin
      int style;
      int left;
      style = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask != hold_seen) begin
            // long hold: results wait in the result buffer and req_stall must rise
            hold_seen = hold_ask;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (left == 0) begin
               style = $urandom_range(0, 3);
               left = $urandom_range(20, 120);
            end
            left--;
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 75);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // ---- main sequence --------------------------------------------------------
   initial begin
      int text_count;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identifiers, number kinds, punctuators, escapes, lone ends
      push_str("a_$9 12.5 3.");
      send_text(1);
      push_str("{}[]();,:.");
      send_text(1);
      push_str("\"q\\\\");
      send_text(1);
      push_str("x&");
      send_text(1);
      push_str("y");
      text_q.push_back(8'h00);
      send_text(0);
      text_q.push_back(8'hFF);
      push_str("zz");
      send_text(1);
      text_q.push_back(8'h0A);
      send_text(1);
      drain();

      // random texts built from fragments
      text_count = 0;
      while (random_sent < 430) begin
         repeat ($urandom_range(3, 15)) add_fragment();
         random_sent += text_q.size();
         if ($urandom_range(0, 9) < 7) begin
            send_text(1);
         end else begin
            text_q.push_back(8'h00);
            random_sent++;
            send_text(0);
         end
         text_count++;
         if (text_count == 3 || text_count == 10) hold_ask++;
         if (text_count == 6 || text_count == 12) drain();
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (tokens_waiting != 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && tokens_waiting == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // run limit, far beyond the slowest legal run
   initial begin
      #8000000;
      $display("Verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/sst_pkg.sv
rtl/core/sst_scan.sv
rtl/core/sst_out.sv
rtl/core/script_source_tokenizer.sv
verif/sst_checker.sv
verif/tb_top.sv
